/* src/ept_pkg.sv */
// ----------------------------------------------------------------------------
// ept_pkg
// Shared widths, register indexes, reset values and controller/datapath types
// for the edge period tachometer.
// ----------------------------------------------------------------------------
`default_nettype none

package ept_pkg;

   localparam int EDGES_WIDTH      = 16;
   localparam int NUM_WIDTH        = 32;
   localparam int PERIOD_OUT_WIDTH = 32;
   localparam int SPEED_WIDTH      = 32;
   localparam int CSR_DATA_WIDTH   = 32;
   localparam int CSR_INDEX_WIDTH  = 1;
   localparam int DIV_COUNT_WIDTH  = $clog2(NUM_WIDTH);

   localparam logic [EDGES_WIDTH-1:0] EDGES_RESET     = 16'd11;
   localparam logic [NUM_WIDTH-1:0]   NUMERATOR_RESET = 32'd800000000;

   typedef logic [CSR_INDEX_WIDTH-1:0] csr_index_type;

   localparam csr_index_type CSR_EDGES_PER_MEASURE = 1'b0;
   localparam csr_index_type CSR_SPEED_NUMERATOR   = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_DIVIDE = 3'b010,
      ST_DONE   = 3'b100
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic accept;      // take the request transaction, update tach state
      logic out_direct;  // load response from cached speed
      logic div_start;   // load divider operands
      logic div_step;    // one quotient bit
      logic out_div;     // load response from divider quotient
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic need_div;
      logic div_last;
      logic rsp_free;
   } status_type;

endpackage

`default_nettype wire

/* src/ept_req_if.sv */
// ----------------------------------------------------------------------------
// ept_req_if
// Request channel: one time-base tick with pin level and clear request.
// ----------------------------------------------------------------------------
`default_nettype none

interface ept_req_if;
   logic valid;
   logic ready;
   logic tach_level;
   logic clear_request;

   modport source (output valid, output tach_level, output clear_request, input ready);
   modport sink   (input valid, input tach_level, input clear_request, output ready);
endinterface

`default_nettype wire

/* src/ept_rsp_if.sv */
// ----------------------------------------------------------------------------
// ept_rsp_if
// Response channel: speed, measured period and capture flag for each tick.
// ----------------------------------------------------------------------------
`default_nettype none

interface ept_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic [ept_pkg::SPEED_WIDTH-1:0]       speed;
   logic [ept_pkg::PERIOD_OUT_WIDTH-1:0]  period_ticks;
   logic                                  new_measure;

   modport source (output valid, output speed, output period_ticks, output new_measure,
                   input ready);
   modport sink   (input valid, input speed, input period_ticks, input new_measure,
                   output ready);
endinterface

`default_nettype wire

/* src/ept_ctrl.sv */
// ----------------------------------------------------------------------------
// ept_ctrl
// Sequencer: takes ticks, starts the bit-serial divide after a capture or a
// numerator write and hands the quotient to the response register.
// ----------------------------------------------------------------------------
`default_nettype none

module ept_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_ready,
   input  ept_pkg::status_type  status,
   output ept_pkg::cmd_type     cmd
);

   ept_pkg::state_type state_ff, state_in;

   assign req_ready = (state_ff == ept_pkg::ST_IDLE) && status.rsp_free;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ept_pkg::ST_IDLE: begin
            if (req_valid && req_ready) begin
               cmd.accept = 1'b1;
               if (status.need_div) begin
                  cmd.div_start = 1'b1;
                  state_in      = ept_pkg::ST_DIVIDE;
               end else begin
                  cmd.out_direct = 1'b1;
               end
            end
         end
         ept_pkg::ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ept_pkg::ST_DONE;
            end
         end
         ept_pkg::ST_DONE: begin
            if (status.rsp_free) begin
               cmd.out_div = 1'b1;
               state_in    = ept_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ept_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ept_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

/* src/ept_datapath.sv */
// ----------------------------------------------------------------------------
// ept_datapath
// Time base, edge counter, period capture, cached speed, restoring divider
// and the response register.
// ----------------------------------------------------------------------------
`default_nettype none

module ept_datapath #(
   parameter int TIME_WIDTH = 32
) (
   input  wire                                    clock,
   input  wire                                    reset,
   input  wire                                    req_tach_level,
   input  wire                                    req_clear_request,
   input  wire                                    csr_write_enable,
   input  wire  [ept_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  wire  [ept_pkg::CSR_DATA_WIDTH-1:0]     csr_write_data,
   input  ept_pkg::cmd_type                       cmd,
   output ept_pkg::status_type                    status,
   input  wire                                    rsp_ready,
   output logic                                   rsp_valid,
   output logic [ept_pkg::SPEED_WIDTH-1:0]        rsp_speed,
   output logic [ept_pkg::PERIOD_OUT_WIDTH-1:0]   rsp_period_ticks,
   output logic                                   rsp_new_measure
);

   localparam int NW = ept_pkg::NUM_WIDTH;
   localparam int EW = ept_pkg::EDGES_WIDTH;

   // configuration
   logic [EW-1:0] edges_per_measure_ff, edges_per_measure_in;
   logic [NW-1:0] speed_numerator_ff, speed_numerator_in;
   logic          dirty_ff, dirty_in;   // numerator changed since last divide

   // tach state
   logic [TIME_WIDTH-1:0] time_base_ff, time_base_in;
   logic [TIME_WIDTH-1:0] last_capture_ff, last_capture_in;
   logic [TIME_WIDTH-1:0] period_ff, period_in;
   logic [EW-1:0]         edges_left_ff, edges_left_in;
   logic                  level_ff, level_in;
   logic [NW-1:0]         speed_cache_ff, speed_cache_in;

   // divider
   logic [NW-1:0]                      dq_ff, dq_in;
   logic [TIME_WIDTH-1:0]              rem_ff, rem_in;
   logic [ept_pkg::DIV_COUNT_WIDTH-1:0] count_ff, count_in;
   logic                               captured_ff, captured_in;

   // response
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic [ept_pkg::SPEED_WIDTH-1:0]      rsp_speed_ff, rsp_speed_in;
   logic [ept_pkg::PERIOD_OUT_WIDTH-1:0] rsp_period_ff, rsp_period_in;
   logic                                 rsp_measure_ff, rsp_measure_in;

   logic                  rise;
   logic                  capture;
   logic [TIME_WIDTH-1:0] period_next;
   logic [TIME_WIDTH:0]   rem_shift;
   logic [TIME_WIDTH:0]   rem_diff;
   logic                  q_bit;

   assign rise        = req_tach_level & ~level_ff;
   assign capture     = rise && (edges_left_ff <= EW'(1));
   assign period_next = req_clear_request ? '0 :
                        capture ? (last_capture_ff - time_base_ff) : period_ff;

   assign rem_shift = {rem_ff, dq_ff[NW-1]};
   assign rem_diff  = rem_shift - {1'b0, period_ff};
   assign q_bit     = ~rem_diff[TIME_WIDTH];

   assign status.need_div = (period_next != '0) && (capture || dirty_ff);
   assign status.div_last = (count_ff == ept_pkg::DIV_COUNT_WIDTH'(NW - 1));
   assign status.rsp_free = ~rsp_valid_ff | rsp_ready;

   always_comb begin
      edges_per_measure_in = edges_per_measure_ff;
      speed_numerator_in   = speed_numerator_ff;
      dirty_in             = dirty_ff;
      time_base_in         = time_base_ff;
      last_capture_in      = last_capture_ff;
      period_in            = period_ff;
      edges_left_in        = edges_left_ff;
      level_in             = level_ff;
      speed_cache_in       = speed_cache_ff;
      captured_in          = captured_ff;
      dq_in                = dq_ff;
      rem_in               = rem_ff;
      count_in             = count_ff;
      rsp_speed_in         = rsp_speed_ff;
      rsp_period_in        = rsp_period_ff;
      rsp_measure_in       = rsp_measure_ff;
      rsp_valid_in         = rsp_valid_ff & ~rsp_ready;

      if (cmd.accept) begin
         level_in     = req_tach_level;
         time_base_in = time_base_ff - TIME_WIDTH'(1);
         period_in    = period_next;
         captured_in  = capture;
         if (capture) begin
            last_capture_in = time_base_ff;
            edges_left_in   = edges_per_measure_ff;
         end else if (rise) begin
            edges_left_in = edges_left_ff - EW'(1);
         end
      end

      if (cmd.out_direct) begin
         // no divide needed: either the period is zero or cached speed is current
         if (period_next == '0) begin
            speed_cache_in = '0;
         end
         dirty_in       = 1'b0;
         rsp_valid_in   = 1'b1;
         rsp_speed_in   = (period_next == '0) ? '0 : speed_cache_ff;
         rsp_period_in  = ept_pkg::PERIOD_OUT_WIDTH'(period_next);
         rsp_measure_in = capture;
      end

      if (cmd.div_start) begin
         dq_in    = speed_numerator_ff;
         rem_in   = '0;
         count_in = '0;
      end

      if (cmd.div_step) begin
         rem_in   = q_bit ? rem_diff[TIME_WIDTH-1:0] : rem_shift[TIME_WIDTH-1:0];
         dq_in    = {dq_ff[NW-2:0], q_bit};
         count_in = count_ff + ept_pkg::DIV_COUNT_WIDTH'(1);
      end

      if (cmd.out_div) begin
         speed_cache_in = dq_ff;
         dirty_in       = 1'b0;
         rsp_valid_in   = 1'b1;
         rsp_speed_in   = dq_ff;
         rsp_period_in  = ept_pkg::PERIOD_OUT_WIDTH'(period_ff);
         rsp_measure_in = captured_ff;
      end

      if (csr_write_enable) begin
         unique case (csr_index)
            ept_pkg::CSR_EDGES_PER_MEASURE: begin
               edges_per_measure_in = csr_write_data[EW-1:0];
            end
            ept_pkg::CSR_SPEED_NUMERATOR: begin
               speed_numerator_in = csr_write_data[NW-1:0];
               dirty_in           = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         edges_per_measure_ff <= ept_pkg::EDGES_RESET;
         speed_numerator_ff   <= ept_pkg::NUMERATOR_RESET;
         dirty_ff             <= 1'b0;
         time_base_ff         <= '1;
         last_capture_ff      <= '0;
         period_ff            <= '0;
         edges_left_ff        <= ept_pkg::EDGES_RESET;
         level_ff             <= 1'b0;
         speed_cache_ff       <= '0;
         rsp_valid_ff         <= 1'b0;
      end else begin
         edges_per_measure_ff <= edges_per_measure_in;
         speed_numerator_ff   <= speed_numerator_in;
         dirty_ff             <= dirty_in;
         time_base_ff         <= time_base_in;
         last_capture_ff      <= last_capture_in;
         period_ff            <= period_in;
         edges_left_ff        <= edges_left_in;
         level_ff             <= level_in;
         speed_cache_ff       <= speed_cache_in;
         rsp_valid_ff         <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      captured_ff    <= captured_in;
      dq_ff          <= dq_in;
      rem_ff         <= rem_in;
      count_ff       <= count_in;
      rsp_speed_ff   <= rsp_speed_in;
      rsp_period_ff  <= rsp_period_in;
      rsp_measure_ff <= rsp_measure_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_speed        = rsp_speed_ff;
   assign rsp_period_ticks = rsp_period_ff;
   assign rsp_new_measure  = rsp_measure_ff;

endmodule

`default_nettype wire

/* src/edge_period_tachometer_unit.sv */
// ----------------------------------------------------------------------------
// edge_period_tachometer_unit
// Period-measuring tachometer: each request transaction is one time-base
// tick; each tick yields one response with speed, period and capture flag.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries one tick per transaction (pin level, clear request).
//   rsp_ch returns exactly one transaction per tick, in order, from an
//   output register.
//   csr_* writes edges_per_measure (index 0) or speed_numerator (index 1);
//   write only while no tick is in flight.
// Timing:
//   A tick that needs no new quotient (no capture, cached speed valid)
//   is answered directly: the response is registered at the accepting
//   edge and the next tick may follow in the next cycle unless rsp_ch stalls.
//   A tick with a nonzero period that is a capture or the first after a
//   numerator write runs the restoring divider one quotient bit per cycle,
//   then loads the quotient into the response register once rsp_ch can
//   take it. No tick is taken meanwhile.
// Reset (synchronous): time base to all ones, counters and period to their
//   initial values, registers to defaults, response register emptied.
// Stall: while rsp_ch.ready is low with a response held, req_ch.ready is low.
// ----------------------------------------------------------------------------
`default_nettype none

module edge_period_tachometer_unit #(
   parameter int TIME_WIDTH = 32
) (
   input  wire                                  clock,
   input  wire                                  reset,
   ept_req_if.sink                              req_ch,
   ept_rsp_if.source                            rsp_ch,
   input  wire                                  csr_write_enable,
   input  wire  [ept_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  wire  [ept_pkg::CSR_DATA_WIDTH-1:0]   csr_write_data
);

   ept_pkg::cmd_type    cmd;
   ept_pkg::status_type status;
   logic                req_ready;

   assign req_ch.ready = req_ready;

   ept_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   ept_datapath #(
      .TIME_WIDTH (TIME_WIDTH)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .req_tach_level    (req_ch.tach_level),
      .req_clear_request (req_ch.clear_request),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .cmd               (cmd),
      .status            (status),
      .rsp_ready         (rsp_ch.ready),
      .rsp_valid         (rsp_ch.valid),
      .rsp_speed         (rsp_ch.speed),
      .rsp_period_ticks  (rsp_ch.period_ticks),
      .rsp_new_measure   (rsp_ch.new_measure)
   );

`ifndef ASSERT_OFF
   // a nonzero speed only comes with a nonzero period
   assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (rsp_ch.period_ticks != '0 || rsp_ch.speed == '0))
      else $error("speed nonzero with zero period");

   // a tick is never taken while a held response cannot drain
   assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |-> (!rsp_ch.valid || rsp_ch.ready))
      else $error("tick accepted over a stalled response");

   // period fits the time base width
   assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> ((rsp_ch.period_ticks >> TIME_WIDTH) == '0))
      else $error("period wider than time base");

   // after a tick that needs no divide is taken, a response is pending or issued by the next edge
   assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready && !cmd.div_start) |=> rsp_ch.valid)
      else $error("response missing after direct tick");
`endif

endmodule

`default_nettype wire

/* tb/tb_edge_period_tachometer_unit.sv */
// ----------------------------------------------------------------------------
// tb_edge_period_tachometer_unit
// Tick-level check of the edge period tachometer. Each request transaction is
// one time-base tick. A tick-accurate software tachometer predicts speed,
// period and capture flag for every tick, and each response transaction is
// checked in order against it. Directed ticks come first, then random pin
// waveforms under several register settings and valid/ready idling phases.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_edge_period_tachometer_unit;

   localparam int CYCLE_LIMIT = 400000;
   localparam int SETTLE_CYCLES = 40;

   typedef struct packed {
      logic [ept_pkg::SPEED_WIDTH-1:0]      speed;
      logic [ept_pkg::PERIOD_OUT_WIDTH-1:0] period_ticks;
      logic                                 new_measure;
   } tach_reading_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                                csr_write_enable = 1'b0;
   logic [ept_pkg::CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [ept_pkg::CSR_DATA_WIDTH-1:0]  csr_write_data = '0;

   ept_req_if req_ch ();
   ept_rsp_if rsp_ch ();

   edge_period_tachometer_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_ch           (req_ch),
      .rsp_ch           (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #4 clock = ~clock;

   // software copy of the tachometer
   logic [ept_pkg::EDGES_WIDTH-1:0] edges_cfg = ept_pkg::EDGES_RESET;
   logic [ept_pkg::NUM_WIDTH-1:0]   numerator_cfg = ept_pkg::NUMERATOR_RESET;
   logic [31:0]                     time_base = 32'hFFFF_FFFF;
   logic [31:0]                     last_capture = '0;
   logic [ept_pkg::EDGES_WIDTH-1:0] edges_left = ept_pkg::EDGES_RESET;
   logic [31:0]                     period_now = '0;
   logic                            pin_prev = 1'b0;

   tach_reading_type expected_readings[$];
   int unsigned      mismatches = 0;
   int unsigned      cycle_count = 0;
   int unsigned      gap_pct = 0;
   int unsigned      stall_pct = 0;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // receiver stalls
   always @(posedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
   end

   // response checker
   always @(posedge clock) begin
      tach_reading_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_readings.size() == 0) begin
            mismatches++;
            $display("%0t: response transaction with none expected: speed %0d period %0d",
                     $time, rsp_ch.speed, rsp_ch.period_ticks);
         end else begin
            want = expected_readings.pop_front();
            if (rsp_ch.speed !== want.speed) begin
               mismatches++;
               $display("%0t: speed expected %0d actual %0d",
                        $time, want.speed, rsp_ch.speed);
            end
            if (rsp_ch.period_ticks !== want.period_ticks) begin
               mismatches++;
               $display("%0t: period_ticks expected %0d actual %0d",
                        $time, want.period_ticks, rsp_ch.period_ticks);
            end
            if (rsp_ch.new_measure !== want.new_measure) begin
               mismatches++;
               $display("%0t: new_measure expected %0b actual %0b",
                        $time, want.new_measure, rsp_ch.new_measure);
            end
         end
      end
   end

   // advance the software tachometer by one tick
   task automatic count_tick(input logic level, input logic clear);
      tach_reading_type r;
      r.new_measure = 1'b0;
      if (level && !pin_prev) begin
         if (edges_left <= 1) begin
            period_now = last_capture - time_base;
            last_capture = time_base;
            edges_left = edges_cfg;
            r.new_measure = 1'b1;
         end else begin
            edges_left = edges_left - 1'b1;
         end
      end
      pin_prev = level;
      if (clear)
         period_now = '0;
      time_base = time_base - 1'b1;
      r.period_ticks = period_now;
      r.speed = (period_now != 0) ? numerator_cfg / period_now : '0;
      expected_readings.push_back(r);
   endtask

   task automatic send_tick(input logic level, input logic clear);
      while ($urandom_range(99) < gap_pct) begin
         req_ch.valid <= 1'b0;
         req_ch.tach_level <= 1'($urandom_range(1));
         req_ch.clear_request <= 1'($urandom_range(1));
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.tach_level <= level;
      req_ch.clear_request <= clear;
      do @(posedge clock); while (!req_ch.ready);
      count_tick(level, clear);
   endtask

   // wait until every tick has been answered; the block is then idle
   task automatic drain;
      req_ch.valid <= 1'b0;
      while (expected_readings.size() != 0)
         @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_register(input ept_pkg::csr_index_type idx,
                                 input logic [31:0] data);
      drain();
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (idx == ept_pkg::CSR_EDGES_PER_MEASURE)
         edges_cfg = data[ept_pkg::EDGES_WIDTH-1:0];
      else if (idx == ept_pkg::CSR_SPEED_NUMERATOR)
         numerator_cfg = data;
   endtask

   // reset edge count of 11 is still loaded; the new count waits for the reload
   task automatic test_first_capture;
      write_register(ept_pkg::CSR_EDGES_PER_MEASURE, 32'd1);
      for (int i = 0; i < 22; i++)
         send_tick(i[0], i == 10);
   endtask

   task automatic test_clear_on_capture;
      send_tick(1'b0, 1'b0);
      send_tick(1'b1, 1'b1);
      send_tick(1'b0, 1'b0);
      send_tick(1'b1, 1'b0);
   endtask

   // an edge count of zero behaves like one
   task automatic test_zero_edge_count;
      write_register(ept_pkg::CSR_EDGES_PER_MEASURE, 32'd0);
      repeat (2) begin
         send_tick(1'b0, 1'b0);
         send_tick(1'b1, 1'b0);
      end
   endtask

   task automatic test_numerator_extremes;
      logic [31:0] values[3];
      values = '{32'd0, 32'd1, 32'hFFFF_FFFF};
      foreach (values[i]) begin
         write_register(ept_pkg::CSR_SPEED_NUMERATOR, values[i]);
         send_tick(1'b0, 1'b0);
         send_tick(1'b1, 1'b0);
      end
   endtask

   // random pin waveform: runs of one level, a little noise, rare clears
   task automatic test_random_waveform(input int unsigned count,
                                       input logic [31:0] edges,
                                       input logic [31:0] numerator,
                                       input int unsigned gap, input int unsigned stall);
      logic level;
      int   run_left;
      write_register(ept_pkg::CSR_EDGES_PER_MEASURE, edges);
      write_register(ept_pkg::CSR_SPEED_NUMERATOR, numerator);
      gap_pct = gap;
      stall_pct = stall;
      level = pin_prev;
      run_left = 0;
      repeat (count) begin
         if (run_left == 0) begin
            level = ~level;
            run_left = $urandom_range(1, ($urandom_range(3) == 0) ? 12 : 3);
         end
         run_left--;
         if ($urandom_range(99) < 8)
            send_tick(1'($urandom_range(1)), $urandom_range(99) < 4);
         else
            send_tick(level, $urandom_range(99) < 4);
      end
      drain();
      gap_pct = 0;
      stall_pct = 0;
   endtask

   initial begin
      req_ch.valid <= 1'b0;
      req_ch.tach_level <= 1'b0;
      req_ch.clear_request <= 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_first_capture();
      test_clear_on_capture();
      test_zero_edge_count();
      test_numerator_extremes();

      test_random_waveform(90, 32'd1, 32'hFFFF_FFFF, 0, 0);
      test_random_waveform(90, 32'd3, $urandom, 78, 0);
      test_random_waveform(90, 32'd2, 32'd1, 0, 78);
      test_random_waveform(90, 32'd65535, $urandom | 32'd1, 22, 22);
      test_random_waveform(90, $urandom_range(1, 5), ept_pkg::NUMERATOR_RESET, 0, 0);

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

`default_nettype wire
